FILE: rtl/core/mbpb_pkg.sv
// Shared types and constants for the mask-to-pixel-bytes expander.
// No dependencies; imported by the front end, queue, back end and top.
`default_nettype none

package mbpb_pkg;

    localparam int ROW_WIDTH_W = 13;
    localparam int DEPTH_W     = 3;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_WIDTH   = 1'b0;
    localparam logic REG_PIXEL_DEPTH = 1'b1;

    typedef enum logic [DEPTH_W-1:0] {
        DEPTH_1BPP  = 3'd0,
        DEPTH_4BPP  = 3'd1,
        DEPTH_8BPP  = 3'd2,
        DEPTH_16BPP = 3'd3,
        DEPTH_24BPP = 3'd4,
        DEPTH_32BPP = 3'd5
    } depth_mode_t;

    // how the back end turns the source byte into output bytes
    typedef enum logic [1:0] {
        KIND_REVERSE = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_PIXEL   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0] row_width;
        logic [DEPTH_W-1:0]     depth;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] units;      // pixels or pairs to emit, 1..8
        logic [2:0] reps;       // bytes per unit, 1..4
        logic       row_last;   // last source byte of the row
        logic       pad;        // pad byte follows at row end
    } desc_t;

endpackage

`default_nettype wire

FILE: rtl/core/mbpb_if.sv
// Valid/ready channel interfaces for the mask input and the pixel output.
// No dependencies.
`default_nettype none

interface mbpb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_byte;

    modport source (output valid, output mask_byte, input ready);
    modport sink   (input valid, input mask_byte, output ready);
endinterface

interface mbpb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       run_last;

    modport source (output valid, output pixel_byte, output row_end, output run_last,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input run_last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mbpb_front.sv
// Front end: accepts mask bytes, tracks the position in the row and builds a
// descriptor per byte. Depends on mbpb_pkg and mbpb_if.
`default_nettype none

module mbpb_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mbpb_pkg::cfg_t cfg,
    mbpb_in_if.sink        mask_in,
    input  logic           queue_full,
    output logic           desc_push,
    output mbpb_pkg::desc_t desc
);
    import mbpb_pkg::*;

    localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
    localparam int POS_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [ROW_WIDTH_W-1:0] w_nz;
    logic [ROW_WIDTH_W-1:0] w;
    logic [ROW_WIDTH_W-1:0] w_m1;
    logic [ROW_WIDTH_W:0]   w_p7;
    logic [ROW_WIDTH_W:0]   w_p1;
    logic [10:0]            src_bytes;
    logic [3:0]             last_px;
    logic                   row_last;
    logic                   pad;

    assign mask_in.ready = !queue_full;
    assign desc_push     = mask_in.valid && !queue_full;

    always_comb
    begin
        w_nz = (cfg.row_width == '0) ? ROW_WIDTH_W'(1) : cfg.row_width;
        w    = (32'(w_nz) > MAX_WIDTH) ? ROW_WIDTH_W'(MAX_WIDTH) : w_nz;
        w_m1 = w - ROW_WIDTH_W'(1);
        w_p7 = {1'b0, w} + (ROW_WIDTH_W+1)'(7);
        w_p1 = {1'b0, w} + (ROW_WIDTH_W+1)'(1);
        src_bytes = w_p7[ROW_WIDTH_W:3];
        last_px   = {1'b0, w_m1[2:0]} + 4'd1;
        row_last  = (32'(pos_reg) + 32'd1) >= 32'(src_bytes);
    end

    // parity of the output row length in bytes
    always_comb
    begin
        unique case (cfg.depth)
            DEPTH_1BPP:               pad = src_bytes[0];
            DEPTH_4BPP:               pad = w_p1[1];
            DEPTH_8BPP, DEPTH_24BPP:  pad = w[0];
            default:                  pad = 1'b0;
        endcase
    end

    always_comb
    begin
        desc.data     = mask_in.mask_byte;
        desc.row_last = row_last;
        desc.pad      = pad;
        unique case (cfg.depth)
            DEPTH_1BPP:
            begin
                desc.kind  = KIND_REVERSE;
                desc.units = 4'd1;
                desc.reps  = 3'd1;
            end
            DEPTH_4BPP:
            begin
                desc.kind  = KIND_PAIR;
                desc.units = row_last ? ((last_px + 4'd1) >> 1) : 4'd4;
                desc.reps  = 3'd1;
            end
            DEPTH_8BPP, DEPTH_16BPP, DEPTH_24BPP:
            begin
                desc.kind  = KIND_PIXEL;
                desc.units = row_last ? last_px : 4'd8;
                desc.reps  = cfg.depth - 3'd1;
            end
            default:
            begin
                desc.kind  = KIND_PIXEL;
                desc.units = row_last ? last_px : 4'd8;
                desc.reps  = 3'd4;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (desc_push)
        begin
            pos_next = row_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mbpb_queue.sv
// Short descriptor queue between front and back end.
// Depends on mbpb_pkg.
`default_nettype none

module mbpb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbpb_pkg::desc_t din,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mbpb_pkg::desc_t dout
);
    import mbpb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mbpb_back.sv
// Back end: walks one descriptor at a time and emits, through an output
// register, one byte per cycle unless stalled. Needs mbpb_pkg, mbpb_if.
`default_nettype none

module mbpb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            desc_valid,
    input  mbpb_pkg::desc_t desc,
    output logic            desc_pop,
    mbpb_out_if.source      pixel_out
);
    import mbpb_pkg::*;

    localparam logic [7:0] PAIR_CODE [4] = '{8'hFF, 8'hF0, 8'h0F, 8'h00};

    logic       busy_reg,  busy_next;
    logic       pad_phase_reg, pad_phase_next;
    kind_t      kind_reg,  kind_next;
    logic [7:0] data_reg,  data_next;
    logic [3:0] units_reg, units_next;
    logic [2:0] reps_reg,  reps_next;
    logic       row_last_reg, row_last_next;
    logic       pad_reg,   pad_next;
    logic [3:0] unit_idx_reg, unit_idx_next;
    logic [2:0] rep_idx_reg,  rep_idx_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_row_end_reg, out_row_end_next;
    logic       out_run_last_reg, out_run_last_next;

    logic       emit;
    logic       unit_done;
    logic       data_end;
    logic       is_final;
    logic [7:0] rev_byte;
    logic [7:0] cur_byte;

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.pixel_byte = out_byte_reg;
    assign pixel_out.row_end    = out_row_end_reg;
    assign pixel_out.run_last   = out_run_last_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rev_byte[7-i] = data_reg[i];
        end
    end

    always_comb
    begin
        if (pad_phase_reg)
        begin
            cur_byte = 8'h00;
        end
        else
        begin
            unique case (kind_reg)
                KIND_REVERSE: cur_byte = rev_byte;
                KIND_PAIR:    cur_byte = PAIR_CODE[data_reg[1:0]];
                default:      cur_byte = data_reg[0] ? 8'h00 : 8'hFF;
            endcase
        end
    end

    always_comb
    begin
        emit      = busy_reg && (!out_valid_reg || pixel_out.ready);
        unit_done = (rep_idx_reg == reps_reg - 3'd1);
        data_end  = unit_done && (unit_idx_reg == units_reg - 4'd1);
        is_final  = pad_phase_reg || (data_end && !pad_reg);
        desc_pop  = desc_valid && (!busy_reg || (emit && is_final));
    end

    // sequencer over pixels/pairs, repeats and the pad byte
    always_comb
    begin
        busy_next      = busy_reg;
        pad_phase_next = pad_phase_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        units_next     = units_reg;
        reps_next      = reps_reg;
        row_last_next  = row_last_reg;
        pad_next       = pad_reg;
        unit_idx_next  = unit_idx_reg;
        rep_idx_next   = rep_idx_reg;
        if (desc_pop)
        begin
            busy_next      = 1'b1;
            pad_phase_next = 1'b0;
            kind_next      = desc.kind;
            data_next      = desc.data;
            units_next     = desc.units;
            reps_next      = desc.reps;
            row_last_next  = desc.row_last;
            pad_next       = desc.pad && desc.row_last;
            unit_idx_next  = '0;
            rep_idx_next   = '0;
        end
        else if (emit)
        begin
            if (is_final)
            begin
                busy_next = 1'b0;
            end
            else if (data_end)
            begin
                pad_phase_next = 1'b1;
            end
            else if (unit_done)
            begin
                rep_idx_next  = '0;
                unit_idx_next = unit_idx_reg + 4'd1;
                data_next     = (kind_reg == KIND_PAIR) ? (data_reg >> 2) : (data_reg >> 1);
            end
            else
            begin
                rep_idx_next = rep_idx_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_row_end_next  = out_row_end_reg;
        out_run_last_next = out_run_last_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_byte_next     = cur_byte;
            out_row_end_next  = is_final && row_last_reg;
            out_run_last_next = is_final;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        data_reg         <= data_next;
        units_reg        <= units_next;
        reps_reg         <= reps_next;
        row_last_reg     <= row_last_next;
        pad_reg          <= pad_next;
        unit_idx_reg     <= unit_idx_next;
        rep_idx_reg      <= rep_idx_next;
        out_byte_reg     <= out_byte_next;
        out_row_end_reg  <= out_row_end_next;
        out_run_last_reg <= out_run_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pad_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pad_phase_reg <= pad_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mask_bits_to_pixel_bytes_top.sv
// Top level of the mask-to-pixel-bytes expander: APB registers, front end,
// descriptor queue and back end. Depends on mbpb_pkg, mbpb_if and submodules.
//
// Expands a 1-bit, LSB-first mask image, one source byte per transaction,
// into pixel bytes at 1/4/8/16/24/32 bpp. The output channel carries one
// byte per cycle, when not stalled, from the back end's output register; an
// input byte produces 1 output byte at 1 bpp, up to 4 at 4 bpp, up to
// 8/16/24/32 at 8..32 bpp, plus the pad byte that ends an odd-length row.
// A two-entry descriptor queue lets the front end take new bytes while the
// back end is still emitting. Registers: row_width_pixels at 0x0,
// pixel_depth_mode at 0x4; write them only while the block is idle.
`default_nettype none

module mask_bits_to_pixel_bytes_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbpb_pkg::ADDR_W-1:0] paddr,
    input  logic [mbpb_pkg::DATA_W-1:0] pwdata,
    output logic [mbpb_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    mbpb_in_if.sink                     mask_in,
    mbpb_out_if.source                  pixel_out
);
    import mbpb_pkg::*;

    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [DEPTH_W-1:0]     depth_reg,     depth_next;
    logic                   reg_sel;
    logic                   cfg_write;
    cfg_t                   cfg;
    desc_t                  push_desc;
    desc_t                  head_desc;
    logic                   desc_push;
    logic                   desc_pop;
    logic                   queue_full;
    logic                   queue_not_empty;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;
    assign cfg.row_width = row_width_reg;
    assign cfg.depth     = depth_reg;

    always_comb
    begin
        row_width_next = row_width_reg;
        depth_next     = depth_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_ROW_WIDTH:   row_width_next = pwdata[ROW_WIDTH_W-1:0];
                REG_PIXEL_DEPTH: depth_next     = pwdata[DEPTH_W-1:0];
                default:         row_width_next = row_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROW_WIDTH:   prdata = DATA_W'(row_width_reg);
            REG_PIXEL_DEPTH: prdata = DATA_W'(depth_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_W'(8);
            depth_reg     <= DEPTH_1BPP;
        end
        else
        begin
            row_width_reg <= row_width_next;
            depth_reg     <= depth_next;
        end
    end

    mbpb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .mask_in    (mask_in),
        .queue_full (queue_full),
        .desc_push  (desc_push),
        .desc       (push_desc)
    );

    mbpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .din       (push_desc),
        .full      (queue_full),
        .pop       (desc_pop),
        .not_empty (queue_not_empty),
        .dout      (head_desc)
    );

    mbpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (queue_not_empty),
        .desc       (head_desc),
        .desc_pop   (desc_pop),
        .pixel_out  (pixel_out)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mbpb_checker.sv
// Port-level checks for the mask-to-pixel-bytes expander, bound to the top.
// Depends on mask_bits_to_pixel_bytes_top's ports only.
`default_nettype none

module mbpb_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_row_end,
    input logic       out_run_last
);

    // a stalled transaction keeps its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_row_end) && $stable(out_run_last))
        else $error("output transaction changed while stalled");

    // a row always ends on the final byte of a source byte
    a_row_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_row_end |-> out_run_last)
        else $error("row_end without run_last");

    // bytes of one source byte follow without gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_run_last |=> out_valid)
        else $error("gap inside the bytes of one source byte");

endmodule

bind mask_bits_to_pixel_bytes_top mbpb_port_checks u_mbpb_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (pixel_out.valid),
    .out_ready    (pixel_out.ready),
    .out_byte     (pixel_out.pixel_byte),
    .out_row_end  (pixel_out.row_end),
    .out_run_last (pixel_out.run_last)
);

`default_nettype wire
